@@ sv/cce_pkg.sv @@
// Shared constants for the C/C++ comment extractor: default counter widths
// and the character codes that the scanner tests against. No dependencies.
package cce_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned LINE_BITS_DEF   = 20;
  localparam int unsigned COLUMN_BITS_DEF = 16;

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

endpackage

@@ sv/cce_if.sv @@
// Valid/ready channels of the comment extractor: source bytes in, comment
// records out. Depends on cce_pkg for the default field widths.
interface cce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_text;

  modport source (output valid, source_byte, end_of_text, input ready);
  modport sink (input valid, source_byte, end_of_text, output ready);
endinterface

interface cce_out_if #(
  parameter int unsigned OFFSET_BITS = cce_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = cce_pkg::LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = cce_pkg::COLUMN_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] comment_start;
  logic [LINE_BITS-1:0]   comment_line;
  logic [COLUMN_BITS-1:0] comment_column;
  logic [OFFSET_BITS-1:0] comment_length;
  logic                   unterminated;
  logic                   last_of_run;

  modport source (output valid, comment_start, comment_line, comment_column,
                  comment_length, unterminated, last_of_run, input ready);
  modport sink (input valid, comment_start, comment_line, comment_column,
                comment_length, unterminated, last_of_run, output ready);
endinterface

@@ sv/c_comment_extractor_unit.sv @@
// Top level of the C/C++ comment extractor: byte queue, scanner state machine,
// counters and the result register. Depends on cce_pkg and cce_if.
//
// The block takes one source byte per clock and reports each comment as one
// result word: start offset, line, column, content length and an unterminated
// flag. Every byte is judged with up to two bytes of lookahead, so the scanner works
// on the byte two places behind the newest one held in a three-entry queue;
// a comment's word is written to the result register when the scanner
// reaches its closer. In steady streaming the rate is one byte per cycle. The
// byte marked end_of_text closes the text: the queue drains one byte a cycle
// while no finished word waits in the output register, and a final step reports
// an open comment and clears all counters; input is held off from that byte
// until the final step is done. Input is also held off only while the
// queue is full and a finished result waits in the output register.
// Positions, lines, lengths and columns saturate at their maximum.
module c_comment_extractor_unit #(
  parameter int unsigned OFFSET_BITS = cce_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LINE_BITS   = cce_pkg::LINE_BITS_DEF,
  parameter int unsigned COLUMN_BITS = cce_pkg::COLUMN_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  cce_in_if.sink     source,
  cce_out_if.source  result
);

  localparam int unsigned CW = OFFSET_BITS + COLUMN_BITS;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_NORMAL,
    ST_PREPROC,
    ST_DQUOTE,
    ST_SQUOTE,
    ST_ESCAPE,
    ST_BLOCK,
    ST_LINE
  } scan_state_t;

  scan_state_t            scan_state, scan_state_next;
  logic                   escape_single, escape_single_next;
  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [OFFSET_BITS-1:0] line_start, line_start_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [LINE_BITS-1:0]   pending_line, pending_line_next;
  logic [COLUMN_BITS-1:0] pending_column, pending_column_next;
  logic [OFFSET_BITS-1:0] pending_length, pending_length_next;
  logic [1:0]             skip_count, skip_count_next;

  logic [7:0] queue [3];
  logic [7:0] queue_next [3];
  logic [1:0] fill, fill_next;
  logic       flush;

  logic                   out_valid;
  logic [OFFSET_BITS-1:0] out_start;
  logic [LINE_BITS-1:0]   out_line;
  logic [COLUMN_BITS-1:0] out_column;
  logic [OFFSET_BITS-1:0] out_length;
  logic                   out_unterm;

  logic [7:0] ch, c1, c2;
  logic       h1, h2;
  logic       open_extra;
  logic [OFFSET_BITS:0]   open_sum;
  logic [OFFSET_BITS-1:0] open_q;
  logic [OFFSET_BITS-1:0] open_diff;
  logic [CW-1:0]          open_diff_w;
  logic [COLUMN_BITS-1:0] open_col;
  logic [OFFSET_BITS-1:0] length_inc;
  logic [LINE_BITS-1:0]   line_inc;

  logic scan_pending, scan_emit, scan_go;
  logic final_pending, term_emit, final_go;
  logic out_free, accept, load;

  assign ch = queue[0];
  assign c1 = queue[1];
  assign c2 = queue[2];
  assign h1 = fill >= 2'd2;
  assign h2 = fill == 2'd3;

  assign out_free      = !out_valid || result.ready;
  assign scan_pending  = (fill == 2'd3) || (flush && fill != 2'd0);
  assign scan_go       = scan_pending && (out_free || !scan_emit);
  assign final_pending = flush && fill == 2'd0;
  assign term_emit     = (scan_state == ST_BLOCK || scan_state == ST_LINE) &&
                         pending_length != '0;
  assign final_go      = final_pending && (out_free || !term_emit);
  assign source.ready  = !flush && (fill != 2'd3 || scan_go);
  assign accept        = source.valid && source.ready;
  assign load          = (scan_go && scan_emit) || (final_go && term_emit);

  // opener position, start and column
  assign open_extra  = h2 && ((c1 == cce_pkg::CH_STAR) ?
                              (c2 inside {cce_pkg::CH_STAR, cce_pkg::CH_BANG}) :
                              (c2 inside {cce_pkg::CH_SLASH, cce_pkg::CH_BANG}));
  assign open_sum    = {1'b0, byte_position} + (OFFSET_BITS+1)'(1) +
                       (OFFSET_BITS+1)'(open_extra);
  assign open_q      = open_sum[OFFSET_BITS] ? OFF_MAX : open_sum[OFFSET_BITS-1:0];
  assign open_diff   = open_q - line_start;
  assign open_diff_w = CW'(open_diff);
  assign open_col    = (open_diff_w > CW'(COL_MAX)) ? COL_MAX :
                       open_diff_w[COLUMN_BITS-1:0];
  assign length_inc  = (pending_length == OFF_MAX) ? pending_length :
                       pending_length + OFFSET_BITS'(1);
  assign line_inc    = (line_count == LINE_MAX) ? line_count :
                       line_count + LINE_BITS'(1);

  // scanner step on the head of the queue
  always_comb begin
    scan_state_next     = scan_state;
    escape_single_next  = escape_single;
    line_count_next     = line_count;
    line_start_next     = line_start;
    pending_start_next  = pending_start;
    pending_line_next   = pending_line;
    pending_column_next = pending_column;
    pending_length_next = pending_length;
    skip_count_next     = skip_count;
    scan_emit           = 1'b0;
    byte_position_next  = (byte_position == OFF_MAX) ? byte_position :
                          byte_position + OFFSET_BITS'(1);
    if (skip_count != 2'd0) begin
      skip_count_next = skip_count - 2'd1;
    end else begin
      case (scan_state)
        ST_PREPROC: begin
          if (ch == cce_pkg::CH_NEWLINE) begin
            line_count_next = line_inc;
            line_start_next = byte_position;
            scan_state_next = ST_NORMAL;
          end
        end
        ST_NORMAL: begin
          if (ch == cce_pkg::CH_HASH) begin
            scan_state_next = ST_PREPROC;
          end else if (ch == cce_pkg::CH_SLASH) begin
            if (h1 && (c1 == cce_pkg::CH_STAR || c1 == cce_pkg::CH_SLASH)) begin
              skip_count_next     = {open_extra, !open_extra};
              pending_start_next  = (open_q == OFF_MAX) ? open_q :
                                    open_q + OFFSET_BITS'(1);
              pending_column_next = open_col;
              pending_line_next   = line_count;
              pending_length_next = '0;
              scan_state_next     = (c1 == cce_pkg::CH_STAR) ? ST_BLOCK : ST_LINE;
            end
          end else if (ch == cce_pkg::CH_NEWLINE) begin
            line_count_next = line_inc;
            line_start_next = byte_position;
          end else if (ch == cce_pkg::CH_DQUOTE) begin
            scan_state_next = ST_DQUOTE;
          end else if (ch == cce_pkg::CH_SQUOTE) begin
            scan_state_next = ST_SQUOTE;
          end
        end
        ST_DQUOTE: begin
          if (ch == cce_pkg::CH_DQUOTE) begin
            scan_state_next = ST_NORMAL;
          end else if (ch == cce_pkg::CH_BSLASH) begin
            escape_single_next = 1'b0;
            scan_state_next    = ST_ESCAPE;
          end
        end
        ST_SQUOTE: begin
          if (ch == cce_pkg::CH_SQUOTE) begin
            scan_state_next = ST_NORMAL;
          end else if (ch == cce_pkg::CH_BSLASH) begin
            escape_single_next = 1'b1;
            scan_state_next    = ST_ESCAPE;
          end
        end
        ST_ESCAPE: begin
          scan_state_next = escape_single ? ST_SQUOTE : ST_DQUOTE;
        end
        ST_BLOCK: begin
          if (ch == cce_pkg::CH_STAR) begin
            if (h1 && c1 == cce_pkg::CH_STAR && h2 && c2 == cce_pkg::CH_SLASH) begin
              skip_count_next     = 2'd2;
              scan_state_next     = ST_NORMAL;
              pending_line_next   = line_count;
              scan_emit           = pending_length != '0;
              pending_length_next = '0;
            end else if (h1 && c1 == cce_pkg::CH_SLASH) begin
              skip_count_next     = 2'd1;
              scan_state_next     = ST_NORMAL;
              pending_line_next   = line_count;
              scan_emit           = pending_length != '0;
              pending_length_next = '0;
            end else begin
              pending_length_next = length_inc;
            end
          end else if (ch == cce_pkg::CH_NEWLINE) begin
            line_count_next = line_inc;
            line_start_next = byte_position;
          end else begin
            pending_length_next = length_inc;
          end
        end
        ST_LINE: begin
          if (ch == cce_pkg::CH_NEWLINE) begin
            pending_line_next   = line_count;
            line_count_next     = line_inc;
            line_start_next     = byte_position;
            scan_state_next     = ST_NORMAL;
            scan_emit           = pending_length != '0;
            pending_length_next = '0;
          end else begin
            pending_length_next = length_inc;
          end
        end
        default: begin
          scan_state_next = ST_NORMAL;
        end
      endcase
    end
  end

  // pop the scanned byte, push the accepted one
  always_comb begin
    queue_next = queue;
    fill_next  = fill;
    if (scan_go) begin
      queue_next[0] = queue[1];
      queue_next[1] = queue[2];
      fill_next     = fill - 2'd1;
    end
    if (accept) begin
      queue_next[fill_next] = source.source_byte;
      fill_next             = fill_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_NORMAL;
      escape_single  <= 1'b0;
      byte_position  <= '0;
      line_count     <= '0;
      line_start     <= '0;
      pending_start  <= '0;
      pending_line   <= '0;
      pending_column <= '0;
      pending_length <= '0;
      skip_count     <= 2'd0;
      fill           <= 2'd0;
      flush          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      queue <= queue_next;
      fill  <= fill_next;
      if (accept && source.end_of_text) begin
        flush <= 1'b1;
      end
      if (scan_go) begin
        scan_state     <= scan_state_next;
        escape_single  <= escape_single_next;
        byte_position  <= byte_position_next;
        line_count     <= line_count_next;
        line_start     <= line_start_next;
        pending_start  <= pending_start_next;
        pending_line   <= pending_line_next;
        pending_column <= pending_column_next;
        pending_length <= pending_length_next;
        skip_count     <= skip_count_next;
      end else if (final_go) begin
        scan_state     <= ST_NORMAL;
        escape_single  <= 1'b0;
        byte_position  <= '0;
        line_count     <= '0;
        line_start     <= '0;
        pending_start  <= '0;
        pending_line   <= '0;
        pending_column <= '0;
        pending_length <= '0;
        skip_count     <= 2'd0;
        flush          <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      out_start  <= pending_start;
      out_column <= pending_column;
      out_length <= pending_length;
      out_line   <= scan_go ? line_count : pending_line;
      out_unterm <= !scan_go;
    end
  end

  assign result.valid          = out_valid;
  assign result.comment_start  = out_start;
  assign result.comment_line   = out_line;
  assign result.comment_column = out_column;
  assign result.comment_length = out_length;
  assign result.unterminated   = out_unterm;
  assign result.last_of_run    = 1'b1;

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.comment_length != '0)
    else $error("empty comment reported");

  a_eot_flush: assert property (@(posedge clk) disable iff (rst)
    (source.valid && source.ready && source.end_of_text) |=> flush)
    else $error("end of text did not start drain");

  a_final_clear: assert property (@(posedge clk) disable iff (rst)
    final_go |=> !flush && byte_position == '0 && line_count == '0 &&
                 scan_state == ST_NORMAL)
    else $error("state not cleared after end of text");

  a_term_word: assert property (@(posedge clk) disable iff (rst)
    (final_go && term_emit) |=> result.valid && result.unterminated)
    else $error("open comment not reported at end of text");

endmodule
